[rtl/core/rcp_pkg.sv]
// shared types, character codes and helpers for the request command parser
package rcp_pkg;

  // parse phases
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_COUNT    = 4'd1,
    PH_COUNT_LF = 4'd2,
    PH_MARK     = 4'd3,
    PH_LEN      = 4'd4,
    PH_LEN_LF   = 4'd5,
    PH_PAYLOAD  = 4'd6,
    PH_SKIP     = 4'd7,
    PH_INLINE   = 4'd8,
    PH_DISCARD  = 4'd9
  } rcp_phase_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERR   = 2'd3
  } rcp_kind_t;

  // configuration register indexes
  localparam logic REG_MAX_ARG  = 1'b0;
  localparam logic REG_MAX_BULK = 1'b1;

  localparam logic [15:0] MAX_ARG_RESET  = 16'd1024;
  localparam logic [29:0] MAX_BULK_RESET = 30'd536870912;

  // result queue depth, at least two
  localparam int RES_DEPTH = 4;

  // character codes
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // one result item
  typedef struct packed {
    rcp_kind_t   kind;
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [15:0] index;
    logic [15:0] total;
    logic [31:0] consumed;
    logic        last_of_run;
  } rcp_res_t;

  // up to two results caused by one byte
  typedef struct packed {
    logic [1:0] n;
    rcp_res_t   r0;
    rcp_res_t   r1;
  } rcp_push_t;

  function automatic rcp_res_t mk_res(rcp_kind_t kind, logic [7:0] data, logic first,
                                      logic last, logic [15:0] index,
                                      logic [15:0] total, logic [31:0] consumed);
    rcp_res_t r;
    r.kind        = kind;
    r.data        = data;
    r.first       = first;
    r.last        = last;
    r.index       = index;
    r.total       = total;
    r.consumed    = consumed;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

[rtl/core/rcp_core.sv]
// parser state registers and the per-byte next-state and result logic
module rcp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [7:0]          byte_in,
  input  logic [15:0]         max_arg,
  input  logic [29:0]         max_bulk,
  output rcp_pkg::rcp_push_t  push
);

  rcp_pkg::rcp_phase_t phase_r, phase_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic        neg_r, neg_nxt;
  logic        digits_r, digits_nxt;
  logic [15:0] args_rem_r, args_rem_nxt;
  logic [15:0] arg_pos_r, arg_pos_nxt;
  logic [29:0] pay_rem_r, pay_rem_nxt;
  logic [1:0]  skip_rem_r, skip_rem_nxt;
  logic [31:0] seen_r, seen_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        held_vld_r, held_vld_nxt;
  logic        cr_pend_r, cr_pend_nxt;
  logic        tok_open_r, tok_open_nxt;

  rcp_pkg::rcp_res_t res [2];
  logic [1:0]  res_n;
  logic        do_inline;
  logic        inl_done;
  logic        is_digit;
  logic [35:0] mul10;
  logic [31:0] accum_dig;
  logic [31:0] count_val;

  // decimal accumulate with saturation
  assign is_digit  = (byte_in >= rcp_pkg::CH_ZERO) && (byte_in <= rcp_pkg::CH_NINE);
  assign mul10     = {1'b0, accum_r, 3'b000} + {3'b000, accum_r, 1'b0}
                   + {32'd0, byte_in[3:0] - rcp_pkg::CH_ZERO[3:0]};
  assign accum_dig = (mul10[35:32] != 4'd0) ? 32'hFFFF_FFFF : mul10[31:0];
  assign count_val = neg_r ? 32'd0 : accum_r;

  // next state and results for one byte
  always_comb begin
    phase_nxt    = phase_r;
    accum_nxt    = accum_r;
    neg_nxt      = neg_r;
    digits_nxt   = digits_r;
    args_rem_nxt = args_rem_r;
    arg_pos_nxt  = arg_pos_r;
    pay_rem_nxt  = pay_rem_r;
    skip_rem_nxt = skip_rem_r;
    seen_nxt     = seen_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    cr_pend_nxt  = cr_pend_r;
    tok_open_nxt = tok_open_r;
    res[0]       = '0;
    res[1]       = '0;
    res_n        = 2'd0;
    do_inline    = 1'b0;
    inl_done     = 1'b0;

    if (phase_r == rcp_pkg::PH_DISCARD) begin
      if (byte_in == rcp_pkg::CH_LF) phase_nxt = rcp_pkg::PH_IDLE;
    end else begin
      // a new command starts from clean counters
      if (phase_r == rcp_pkg::PH_IDLE) begin
        seen_nxt     = 32'd0;
        arg_pos_nxt  = 16'd0;
        args_rem_nxt = 16'd0;
        held_vld_nxt = 1'b0;
        cr_pend_nxt  = 1'b0;
        tok_open_nxt = 1'b0;
      end
      if (seen_nxt != 32'hFFFF_FFFF) seen_nxt = seen_nxt + 32'd1;

      case (phase_r)
        rcp_pkg::PH_IDLE: begin
          if (byte_in == rcp_pkg::CH_STAR) begin
            accum_nxt  = 32'd0;
            neg_nxt    = 1'b0;
            digits_nxt = 1'b0;
            phase_nxt  = rcp_pkg::PH_COUNT;
          end else begin
            phase_nxt = rcp_pkg::PH_INLINE;
            do_inline = 1'b1;
          end
        end
        rcp_pkg::PH_COUNT, rcp_pkg::PH_LEN: begin
          if (is_digit) begin
            accum_nxt  = accum_dig;
            digits_nxt = 1'b1;
          end else if (byte_in == rcp_pkg::CH_MINUS && !digits_r && !neg_r) begin
            neg_nxt = 1'b1;
          end else if (byte_in == rcp_pkg::CH_CR && digits_r) begin
            phase_nxt = (phase_r == rcp_pkg::PH_COUNT) ? rcp_pkg::PH_COUNT_LF
                                                        : rcp_pkg::PH_LEN_LF;
          end else begin
            res[res_n[0]] = rcp_pkg::mk_res(rcp_pkg::KIND_ERR, 8'd0, 1'b0, 1'b0,
                                            16'd0, 16'd0, 32'd0);
            res_n     = res_n + 2'd1;
            phase_nxt = (byte_in == rcp_pkg::CH_LF) ? rcp_pkg::PH_IDLE
                                                    : rcp_pkg::PH_DISCARD;
          end
        end
        rcp_pkg::PH_COUNT_LF: begin
          if (byte_in != rcp_pkg::CH_LF || count_val > {16'd0, max_arg}) begin
            res[res_n[0]] = rcp_pkg::mk_res(rcp_pkg::KIND_ERR, 8'd0, 1'b0, 1'b0,
                                            16'd0, 16'd0, 32'd0);
            res_n     = res_n + 2'd1;
            phase_nxt = (byte_in == rcp_pkg::CH_LF) ? rcp_pkg::PH_IDLE
                                                    : rcp_pkg::PH_DISCARD;
          end else if (count_val == 32'd0) begin
            res[res_n[0]] = rcp_pkg::mk_res(rcp_pkg::KIND_DONE, 8'd0, 1'b0, 1'b0,
                                            16'd0, arg_pos_nxt, seen_nxt);
            res_n     = res_n + 2'd1;
            phase_nxt = rcp_pkg::PH_IDLE;
          end else begin
            args_rem_nxt = count_val[15:0];
            arg_pos_nxt  = 16'd0;
            phase_nxt    = rcp_pkg::PH_MARK;
          end
        end
        rcp_pkg::PH_MARK: begin
          if (byte_in == rcp_pkg::CH_DOLLAR) begin
            accum_nxt  = 32'd0;
            neg_nxt    = 1'b0;
            digits_nxt = 1'b0;
            phase_nxt  = rcp_pkg::PH_LEN;
          end else begin
            res[res_n[0]] = rcp_pkg::mk_res(rcp_pkg::KIND_ERR, 8'd0, 1'b0, 1'b0,
                                            16'd0, 16'd0, 32'd0);
            res_n     = res_n + 2'd1;
            phase_nxt = (byte_in == rcp_pkg::CH_LF) ? rcp_pkg::PH_IDLE
                                                    : rcp_pkg::PH_DISCARD;
          end
        end
        rcp_pkg::PH_LEN_LF: begin
          if (byte_in != rcp_pkg::CH_LF || (neg_r && accum_r != 32'd0) ||
              accum_r > {2'd0, max_bulk}) begin
            res[res_n[0]] = rcp_pkg::mk_res(rcp_pkg::KIND_ERR, 8'd0, 1'b0, 1'b0,
                                            16'd0, 16'd0, 32'd0);
            res_n     = res_n + 2'd1;
            phase_nxt = (byte_in == rcp_pkg::CH_LF) ? rcp_pkg::PH_IDLE
                                                    : rcp_pkg::PH_DISCARD;
          end else if (accum_r == 32'd0) begin
            res[res_n[0]] = rcp_pkg::mk_res(rcp_pkg::KIND_EMPTY, 8'd0, 1'b1, 1'b1,
                                            arg_pos_nxt, 16'd0, 32'd0);
            res_n        = res_n + 2'd1;
            skip_rem_nxt = 2'd2;
            phase_nxt    = rcp_pkg::PH_SKIP;
          end else begin
            pay_rem_nxt  = accum_r[29:0];
            tok_open_nxt = 1'b0;
            phase_nxt    = rcp_pkg::PH_PAYLOAD;
          end
        end
        rcp_pkg::PH_PAYLOAD: begin
          res[res_n[0]] = rcp_pkg::mk_res(rcp_pkg::KIND_BYTE, byte_in, !tok_open_r,
                                          pay_rem_r == 30'd1, arg_pos_nxt,
                                          16'd0, 32'd0);
          res_n        = res_n + 2'd1;
          tok_open_nxt = 1'b1;
          if (pay_rem_r != 30'd0) pay_rem_nxt = pay_rem_r - 30'd1;
          if (pay_rem_nxt == 30'd0) begin
            tok_open_nxt = 1'b0;
            skip_rem_nxt = 2'd2;
            phase_nxt    = rcp_pkg::PH_SKIP;
          end
        end
        rcp_pkg::PH_SKIP: begin
          if (skip_rem_r != 2'd0) skip_rem_nxt = skip_rem_r - 2'd1;
          if (skip_rem_nxt == 2'd0) begin
            if (arg_pos_nxt != 16'hFFFF) arg_pos_nxt = arg_pos_nxt + 16'd1;
            if (args_rem_nxt != 16'd0) args_rem_nxt = args_rem_nxt - 16'd1;
            if (args_rem_nxt == 16'd0) begin
              res[res_n[0]] = rcp_pkg::mk_res(rcp_pkg::KIND_DONE, 8'd0, 1'b0, 1'b0,
                                              16'd0, arg_pos_nxt, seen_nxt);
              res_n     = res_n + 2'd1;
              phase_nxt = rcp_pkg::PH_IDLE;
            end else begin
              phase_nxt = rcp_pkg::PH_MARK;
            end
          end
        end
        rcp_pkg::PH_INLINE: begin
          do_inline = 1'b1;
        end
        default: begin
          phase_nxt = rcp_pkg::PH_IDLE;
        end
      endcase

      // inline form: tokens split at spaces, each byte held back by one
      if (do_inline) begin
        if (cr_pend_nxt) begin
          cr_pend_nxt = 1'b0;
          if (byte_in == rcp_pkg::CH_LF) begin
            if (held_vld_nxt) begin
              res[res_n[0]] = rcp_pkg::mk_res(rcp_pkg::KIND_BYTE, held_nxt,
                                              !tok_open_nxt, 1'b1, arg_pos_nxt,
                                              16'd0, 32'd0);
              res_n        = res_n + 2'd1;
              held_vld_nxt = 1'b0;
              tok_open_nxt = 1'b0;
              if (arg_pos_nxt != 16'hFFFF) arg_pos_nxt = arg_pos_nxt + 16'd1;
            end
            res[res_n[0]] = rcp_pkg::mk_res(rcp_pkg::KIND_DONE, 8'd0, 1'b0, 1'b0,
                                            16'd0, arg_pos_nxt, seen_nxt);
            res_n     = res_n + 2'd1;
            phase_nxt = rcp_pkg::PH_IDLE;
            inl_done  = 1'b1;
          end else begin
            // a lone carriage return is an ordinary token byte
            if (held_vld_nxt) begin
              res[res_n[0]] = rcp_pkg::mk_res(rcp_pkg::KIND_BYTE, held_nxt,
                                              !tok_open_nxt, 1'b0, arg_pos_nxt,
                                              16'd0, 32'd0);
              res_n        = res_n + 2'd1;
              tok_open_nxt = 1'b1;
            end
            held_nxt     = rcp_pkg::CH_CR;
            held_vld_nxt = 1'b1;
          end
        end
        if (!inl_done) begin
          if (byte_in == rcp_pkg::CH_SPACE) begin
            if (held_vld_nxt) begin
              res[res_n[0]] = rcp_pkg::mk_res(rcp_pkg::KIND_BYTE, held_nxt,
                                              !tok_open_nxt, 1'b1, arg_pos_nxt,
                                              16'd0, 32'd0);
              res_n        = res_n + 2'd1;
              held_vld_nxt = 1'b0;
              tok_open_nxt = 1'b0;
              if (arg_pos_nxt != 16'hFFFF) arg_pos_nxt = arg_pos_nxt + 16'd1;
            end
          end else if (byte_in == rcp_pkg::CH_CR) begin
            cr_pend_nxt = 1'b1;
          end else begin
            if (held_vld_nxt) begin
              res[res_n[0]] = rcp_pkg::mk_res(rcp_pkg::KIND_BYTE, held_nxt,
                                              !tok_open_nxt, 1'b0, arg_pos_nxt,
                                              16'd0, 32'd0);
              res_n        = res_n + 2'd1;
              tok_open_nxt = 1'b1;
            end
            held_nxt     = byte_in;
            held_vld_nxt = 1'b1;
          end
        end
      end
    end

    // mark the last result of this byte
    if (res_n == 2'd1) res[0].last_of_run = 1'b1;
    if (res_n == 2'd2) res[1].last_of_run = 1'b1;
  end

  // results handed to the queue in the accept cycle
  always_comb begin
    push.n  = acc ? res_n : 2'd0;
    push.r0 = res[0];
    push.r1 = res[1];
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= rcp_pkg::PH_IDLE;
      accum_r    <= 32'd0;
      neg_r      <= 1'b0;
      digits_r   <= 1'b0;
      args_rem_r <= 16'd0;
      arg_pos_r  <= 16'd0;
      pay_rem_r  <= 30'd0;
      skip_rem_r <= 2'd0;
      seen_r     <= 32'd0;
      held_r     <= 8'd0;
      held_vld_r <= 1'b0;
      cr_pend_r  <= 1'b0;
      tok_open_r <= 1'b0;
    end else if (acc) begin
      phase_r    <= phase_nxt;
      accum_r    <= accum_nxt;
      neg_r      <= neg_nxt;
      digits_r   <= digits_nxt;
      args_rem_r <= args_rem_nxt;
      arg_pos_r  <= arg_pos_nxt;
      pay_rem_r  <= pay_rem_nxt;
      skip_rem_r <= skip_rem_nxt;
      seen_r     <= seen_nxt;
      held_r     <= held_nxt;
      held_vld_r <= held_vld_nxt;
      cr_pend_r  <= cr_pend_nxt;
      tok_open_r <= tok_open_nxt;
    end
  end

  // an error always leads to restart or to dropping up to the line end
  a_err_recover: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && res_n != 2'd0 && res[0].kind == rcp_pkg::KIND_ERR)
    |=> (phase_r == rcp_pkg::PH_IDLE || phase_r == rcp_pkg::PH_DISCARD))
    else $error("error result without recovery phase");

  // a completed command returns the parser to idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && res_n != 2'd0 &&
     (res[0].kind == rcp_pkg::KIND_DONE || res[1].kind == rcp_pkg::KIND_DONE))
    |=> phase_r == rcp_pkg::PH_IDLE)
    else $error("command complete without return to idle");

  // payload phase always holds a nonzero remaining length
  a_pay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == rcp_pkg::PH_PAYLOAD |-> pay_rem_r != 30'd0)
    else $error("payload phase with zero length left");

endmodule

[rtl/core/rcp_res_fifo.sv]
// result queue taking up to two results per cycle and giving one
module rcp_res_fifo #(
  parameter int Depth = rcp_pkg::RES_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rcp_pkg::rcp_push_t push,
  input  logic               pop,
  output rcp_pkg::rcp_res_t  head,
  output logic               head_vld,
  output logic               room
);

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  rcp_pkg::rcp_res_t mem [Depth];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PW-1:0] wr_p1, wr_p2;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop_ok;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PW'(Depth - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wr_p1    = ptr_inc(wr_r);
  assign wr_p2    = ptr_inc(wr_p1);
  assign head     = mem[rd_r];
  assign head_vld = cnt_r != '0;
  assign room     = cnt_r <= CW'(Depth - 2);
  assign pop_ok   = pop && head_vld;

  // pointer and fill count update
  always_comb begin
    case (push.n)
      2'd1:    wr_nxt = wr_p1;
      2'd2:    wr_nxt = wr_p2;
      default: wr_nxt = wr_r;
    endcase
    rd_nxt  = pop_ok ? ptr_inc(rd_r) : rd_r;
    cnt_nxt = cnt_r + CW'(push.n) - CW'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wr_r] <= push.r0;
    if (push.n == 2'd2) mem[wr_p1] <= push.r1;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(push.n) <= CW'(Depth) - cnt_r)
    else $error("result queue overflow");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(Depth))
    else $error("result queue count out of range");

  a_pop_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_ok && push.n == 2'd0) |=> cnt_r == $past(cnt_r) - CW'(1))
    else $error("result queue count not decremented on pop");

endmodule

[rtl/core/resp_command_parser.sv]
// top level of the request command parser: config registers, parser core, result queue
//
// Byte-stream parser for multi-bulk and inline key-value request commands.
// Input channel: one stream byte per beat on in_tdata. Result channel: one result
// per beat; out_tuser carries the result kind (argument byte, empty argument,
// command complete, error) and out_tlast marks the last result caused by one
// input byte (a byte causes zero, one or two results).
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (0 largest
// argument count, 1 largest bulk length); the user must write only while the
// parser is idle; the block does not enforce it. Results leave via the result queue.
// Throughput: one byte per cycle while results drain at one per cycle; the
// result queue (RESULT_DEPTH entries) takes a byte only when it has room for
// two results, so a byte that gives two results can slow intake when the
// receiver also takes one result a cycle.
// Reset (synchronous, rst_n low) puts the parser in its idle phase, empties the
// result queue and restores the register defaults.
// When the receiver stalls, results wait in the queue and in_tready falls once
// fewer than two entries are free; nothing is dropped.
module resp_command_parser #(
  parameter int RESULT_DEPTH = rcp_pkg::RES_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // input byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [7:0] data, [8] arg_first, [9] arg_last,
                                  // [25:10] arg_index, [41:26] arg_total,
                                  // [73:42] consumed, [79:74] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,  // last result of the input byte
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [29:0] cfg_wdata
);

  logic [15:0]        max_arg_r;
  logic [29:0]        max_bulk_r;
  logic               in_acc;
  rcp_pkg::rcp_push_t push;
  rcp_pkg::rcp_res_t  head;

  // limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_arg_r  <= rcp_pkg::MAX_ARG_RESET;
      max_bulk_r <= rcp_pkg::MAX_BULK_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        rcp_pkg::REG_MAX_ARG:  max_arg_r  <= cfg_wdata[15:0];
        rcp_pkg::REG_MAX_BULK: max_bulk_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_acc = in_tvalid && in_tready;

  rcp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (in_acc),
    .byte_in  (in_tdata),
    .max_arg  (max_arg_r),
    .max_bulk (max_bulk_r),
    .push     (push)
  );

  rcp_res_fifo #(
    .Depth (RESULT_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (out_tready),
    .head     (head),
    .head_vld (out_tvalid),
    .room     (in_tready)
  );

  // result beat packing
  assign out_tdata = {6'd0, head.consumed, head.total, head.index,
                      head.last, head.first, head.data};
  assign out_tuser = head.kind;
  assign out_tlast = head.last_of_run;

endmodule
